>>> rtl/core/dvr_pkg.sv
// shared codes, constants and double-precision arithmetic functions for the reduction block
package dvr_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic [1:0] {
    OP_SUM     = 2'd0,
    OP_PRODUCT = 2'd1,
    OP_MIN     = 2'd2,
    OP_MAX     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ELEM  = 2'd0,
    KIND_LAST  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [DW-1:0] BITS_ZERO    = 64'h0000_0000_0000_0000;
  localparam logic [DW-1:0] BITS_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [DW-1:0] BITS_DEF_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [DW-1:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [10:0]   EXP_MAX      = 11'h7FF;

  function automatic logic is_nan(input logic [DW-1:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [DW-1:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [DW-1:0] v);
    return v[62:0] == 63'd0;
  endfunction

  // ordered strict less-than, false when either side is a nan
  function automatic logic fp_lt(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if (is_zero(a) && is_zero(b)) r = 1'b0;
    else if (a[63] != b[63]) r = a[63];
    else if (!a[63]) r = a[62:0] < b[62:0];
    else r = a[62:0] > b[62:0];
    return r;
  endfunction

  // pack with round to nearest even; carry out of the fraction bumps the exponent
  function automatic logic [DW-1:0] fp_round(input logic sgn, input logic [10:0] expf,
                                             input logic [52:0] mant, input logic g,
                                             input logic s);
    logic       inc;
    logic [62:0] mag;
    inc = g & (s | mant[0]);
    mag = {expf, mant[51:0]} + {62'd0, inc};
    return {sgn, mag};
  endfunction

  function automatic logic [DW-1:0] fp_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] l, s, r;
    logic [11:0]   el, es, d, e;
    logic [55:0]   ms, sh, mask, n;
    logic [56:0]   ml, sum;
    logic          sub, lost, found;
    logic [5:0]    lz, shl;
    r = BITS_ZERO;
    if (is_nan(a)) r = a | QUIET_BIT;
    else if (is_nan(b)) r = b | QUIET_BIT;
    else if (is_inf(a) && is_inf(b)) r = (a[63] == b[63]) ? a : BITS_DEF_NAN;
    else if (is_inf(a)) r = a;
    else if (is_inf(b)) r = b;
    else begin
      if (a[62:0] >= b[62:0]) begin
        l = a; s = b;
      end else begin
        l = b; s = a;
      end
      el  = (l[62:52] == 11'd0) ? 12'd1 : {1'b0, l[62:52]};
      es  = (s[62:52] == 11'd0) ? 12'd1 : {1'b0, s[62:52]};
      d   = el - es;
      sub = l[63] ^ s[63];
      ml  = {1'b0, l[62:52] != 11'd0, l[51:0], 3'b000};
      ms  = {s[62:52] != 11'd0, s[51:0], 3'b000};
      if (d >= 12'd56) begin
        sh   = 56'd0;
        lost = ms != 56'd0;
      end else begin
        sh   = ms >> d[5:0];
        mask = ~({56{1'b1}} << d[5:0]);
        lost = (ms & mask) != 56'd0;
      end
      sh[0] = sh[0] | lost;
      sum = sub ? (ml - {1'b0, sh}) : (ml + {1'b0, sh});
      if (sum == 57'd0) begin
        r = {l[63] & s[63], 63'd0};
      end else if (sum[56]) begin
        n = sum[56:1];
        n[0] = n[0] | sum[0];
        e = el + 12'd1;
        if (e >= {1'b0, EXP_MAX}) r = {l[63], EXP_MAX, 52'd0};
        else r = fp_round(l[63], e[10:0], n[55:3], n[2], n[1] | n[0]);
      end else begin
        lz = 6'd0;
        found = 1'b0;
        for (int i = 55; i >= 0; i--) begin
          if (!found && sum[i]) begin
            lz = 6'(55 - i);
            found = 1'b1;
          end
        end
        shl = ({6'd0, lz} > (el - 12'd1)) ? 6'(el - 12'd1) : lz;
        n = sum[55:0] << shl;
        e = el - {6'd0, shl};
        r = fp_round(l[63], n[55] ? e[10:0] : 11'd0, n[55:3], n[2], n[1] | n[0]);
      end
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] fp_mul(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0]     r;
    logic              sg, found, lost;
    logic [52:0]       ma, mb;
    logic [31:0]       al, bl;
    logic [20:0]       ah, bh;
    logic [63:0]       pll;
    logic [52:0]       plh, phl;
    logic [41:0]       phh;
    logic [105:0]      p, pn, q, mask;
    logic [6:0]        lzp;
    logic signed [13:0] e, shr;
    r  = BITS_ZERO;
    sg = a[63] ^ b[63];
    if (is_nan(a)) r = a | QUIET_BIT;
    else if (is_nan(b)) r = b | QUIET_BIT;
    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) r = BITS_DEF_NAN;
    else if (is_inf(a) || is_inf(b)) r = {sg, EXP_MAX, 52'd0};
    else if (is_zero(a) || is_zero(b)) r = {sg, 63'd0};
    else begin
      ma = {a[62:52] != 11'd0, a[51:0]};
      mb = {b[62:52] != 11'd0, b[51:0]};
      // significand product built from four partial products
      {ah, al} = ma;
      {bh, bl} = mb;
      pll = al * bl;
      plh = al * bh;
      phl = ah * bl;
      phh = ah * bh;
      p  = {42'd0, pll} + {21'd0, plh, 32'd0} + {21'd0, phl, 32'd0} + {phh, 64'd0};
      lzp = 7'd0;
      found = 1'b0;
      for (int i = 105; i >= 0; i--) begin
        if (!found && p[i]) begin
          lzp = 7'(105 - i);
          found = 1'b1;
        end
      end
      pn = p << lzp;
      e  = 14'sd0 + $signed({3'd0, (a[62:52] == 11'd0) ? 11'd1 : a[62:52]})
         + $signed({3'd0, (b[62:52] == 11'd0) ? 11'd1 : b[62:52]})
         - 14'sd1022 - $signed({7'd0, lzp});
      if (e >= 14'sd2047) begin
        r = {sg, EXP_MAX, 52'd0};
      end else if (e > 14'sd0) begin
        r = fp_round(sg, e[10:0], pn[105:53], pn[52], pn[51:0] != 52'd0);
      end else begin
        shr = 14'sd1 - e;
        if (shr >= 14'sd106) begin
          q    = 106'd0;
          lost = 1'b1;
        end else begin
          q    = pn >> shr[6:0];
          mask = ~({106{1'b1}} << shr[6:0]);
          lost = (pn & mask) != 106'd0;
        end
        r = fp_round(sg, 11'd0, q[105:53], q[52], (q[51:0] != 52'd0) | lost);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/double_vector_reduction.sv
// Streaming double-precision reduction (sum, product, min, max) over vectors.
// One item is taken every clock cycle unless stalled: the whole fold (a full
// double add or multiply with round to nearest even, or an ordered compare)
// sits in the one logic level between the input ports and the accumulator and
// result registers. A result appears in the cycle after the last element or empty
// marker is transferred and is held in the output register until taken; input is
// taken while that register is empty or being emptied. cfg_we writes the mode
// (0 sum, 1 product, 2 min, 3 max) and must only be used while the block is idle.
module double_vector_reduction
  import dvr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_kind,
  input  logic [DW-1:0] in_element_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_result_value,
  output logic          out_status
);

  op_t           op_r;
  logic [DW-1:0] acc_r, acc_nxt;
  logic          first_r, first_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic          status_r, status_nxt;
  logic [DW-1:0] folded;
  logic          take;
  kind_t         kind;

  assign kind     = kind_t'(in_kind);
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // fold of the incoming element into the held value
  always_comb begin
    folded = acc_r;
    case (op_r)
      OP_SUM:     folded = fp_add(first_r ? BITS_ZERO : acc_r, in_element_value);
      OP_PRODUCT: folded = fp_mul(first_r ? BITS_ONE : acc_r, in_element_value);
      OP_MIN:     folded = (first_r || fp_lt(in_element_value, acc_r)) ?
                           in_element_value : acc_r;
      default:    folded = (first_r || fp_lt(acc_r, in_element_value)) ?
                           in_element_value : acc_r;
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    status_nxt    = status_r;
    if (take) begin
      case (kind)
        KIND_ELEM: begin
          acc_nxt   = folded;
          first_nxt = 1'b0;
        end
        KIND_LAST: begin
          res_nxt       = folded;
          status_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          acc_nxt       = BITS_ZERO;
          first_nxt     = 1'b1;
        end
        KIND_EMPTY: begin
          out_valid_nxt = 1'b1;
          acc_nxt       = BITS_ZERO;
          first_nxt     = 1'b1;
          if (!first_r) begin
            res_nxt    = acc_r;
            status_nxt = 1'b0;
          end else begin
            case (op_r)
              OP_SUM: begin
                res_nxt = BITS_ZERO; status_nxt = 1'b0;
              end
              OP_PRODUCT: begin
                res_nxt = BITS_ONE; status_nxt = 1'b0;
              end
              default: begin
                res_nxt = BITS_ZERO; status_nxt = 1'b1;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_SUM;
      acc_r       <= BITS_ZERO;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) op_r <= op_t'(cfg_wdata);
      acc_r       <= acc_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_status       = status_r;

  // an error status only ever carries a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> res_r == BITS_ZERO)
    else $error("error status with non-zero value");

  // a closing transfer always leaves a result and a fresh accumulator
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    take && (kind == KIND_LAST || kind == KIND_EMPTY)
    |=> out_valid_r && first_r && acc_r == BITS_ZERO)
    else $error("vector close did not produce a result");

  // an element transfer marks the vector as started
  a_elem: assert property (@(posedge clk) disable iff (!rst_n)
    take && kind == KIND_ELEM |=> !first_r)
    else $error("element did not clear first flag");

  // while no element is held the accumulator stays at zero
  a_idle_acc: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> acc_r == BITS_ZERO)
    else $error("accumulator not cleared at vector start");

endmodule

>>> tb/tb_double_vector_reduction.sv
// self-checking testbench for the streaming double-precision reduction block
module tb_double_vector_reduction;
  import dvr_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [DW-1:0] value;
    logic          status;
  } reduction_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [1:0]    cfg_wdata;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    in_kind;
  logic [DW-1:0] in_element_value;
  logic          out_valid;
  logic          out_ready;
  logic [DW-1:0] out_result_value;
  logic          out_status;

  reduction_t    pending_results[$];
  op_t           cur_op;
  logic [DW-1:0] running_acc;
  logic          no_elem_yet;
  int            fail_count;
  int            idle_cycles;
  bit            hold_req;
  int            burst_left;

  double_vector_reduction dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_element_value(in_element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------- reference arithmetic in native reals ----------------
  function automatic bit nan_bits(input logic [DW-1:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
  endfunction

  // nan results: first nan operand made quiet, else the default nan
  function automatic logic [DW-1:0] dbl_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] r;
    if (nan_bits(a)) return a | QUIET_BIT;
    if (nan_bits(b)) return b | QUIET_BIT;
    r = $realtobits($bitstoreal(a) + $bitstoreal(b));
    return nan_bits(r) ? BITS_DEF_NAN : r;
  endfunction

  function automatic logic [DW-1:0] dbl_mul(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] r;
    if (nan_bits(a)) return a | QUIET_BIT;
    if (nan_bits(b)) return b | QUIET_BIT;
    r = $realtobits($bitstoreal(a) * $bitstoreal(b));
    return nan_bits(r) ? BITS_DEF_NAN : r;
  endfunction

  task automatic fold_element(input logic [DW-1:0] x);
    if (no_elem_yet) begin
      case (cur_op)
        OP_SUM:     running_acc = dbl_add(BITS_ZERO, x);
        OP_PRODUCT: running_acc = dbl_mul(BITS_ONE, x);
        default:    running_acc = x;
      endcase
      no_elem_yet = 1'b0;
    end else begin
      case (cur_op)
        OP_SUM:     running_acc = dbl_add(running_acc, x);
        OP_PRODUCT: running_acc = dbl_mul(running_acc, x);
        OP_MIN:     if ($bitstoreal(x) < $bitstoreal(running_acc)) running_acc = x;
        default:    if ($bitstoreal(x) > $bitstoreal(running_acc)) running_acc = x;
      endcase
    end
  endtask

  task automatic close_vector();
    reduction_t r;
    r.value = running_acc;
    r.status = 1'b0;
    if (no_elem_yet) begin
      case (cur_op)
        OP_SUM:     r.value = BITS_ZERO;
        OP_PRODUCT: r.value = BITS_ONE;
        default: begin
          r.value = BITS_ZERO;
          r.status = 1'b1;
        end
      endcase
    end
    pending_results.push_back(r);
    running_acc = BITS_ZERO;
    no_elem_yet = 1'b1;
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic send_item(input kind_t k, input logic [DW-1:0] v);
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= k;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    case (k)
      KIND_ELEM: fold_element(v);
      KIND_LAST: begin
        fold_element(v);
        close_vector();
      end
      KIND_EMPTY: close_vector();
      default: ;
    endcase
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input op_t m);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cur_op = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DW-1:0] rand_element();
    logic [DW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: case ($urandom_range(0, 9))
        0: v = BITS_ZERO;
        1: v = 64'h8000_0000_0000_0000;
        2: v = 64'h7FF0_0000_0000_0000;
        3: v = 64'hFFF0_0000_0000_0000;
        4: v = {v[63], 11'h7FF, 1'b1, v[50:0]};
        5: v = {v[63], 11'h7FF, 1'b0, v[50:1], 1'b1};
        6: v = {v[63], 11'd0, v[51:0]};
        7: v = {v[63], 11'h7FE, v[51:0]};
        8: v = {v[63], 63'h3FF0_0000_0000_0000};
        default: v = {v[63], 11'd1, v[51:0]};
      endcase
      default: v[62:52] = 11'(1023 + $urandom_range(0, 16) - 8);
    endcase
    return v;
  endfunction

  function automatic kind_t rand_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return KIND_ELEM;
    if (p < 90) return KIND_LAST;
    if (p < 97) return KIND_EMPTY;
    return KIND_NONE;
  endfunction

  task automatic send_bursty(input kind_t k, input logic [DW-1:0] v);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(k, v);
  endtask

  // ---------------- tests ----------------
  task automatic test_empty_vectors();
    op_t m;
    for (int i = 0; i < 4; i++) begin
      m = op_t'(i);
      set_mode(m);
      send_item(KIND_EMPTY, {$urandom, $urandom});
    end
  endtask

  task automatic test_sum_cases();
    set_mode(OP_SUM);
    // negative zeros only must give positive zero
    send_item(KIND_ELEM, 64'h8000_0000_0000_0000);
    send_item(KIND_LAST, 64'h8000_0000_0000_0000);
    send_item(KIND_ELEM, 64'h7FEF_FFFF_FFFF_FFFF);
    send_item(KIND_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_ELEM, 64'h7FEF_FFFF_FFFF_FFFF);
    // end marker after elements closes without adding
    send_item(KIND_EMPTY, BITS_ONE);
    send_item(KIND_ELEM, 64'h7FF0_0000_0000_0000);
    send_item(KIND_LAST, 64'hFFF0_0000_0000_0000);
  endtask

  task automatic test_product_cases();
    set_mode(OP_PRODUCT);
    send_item(KIND_ELEM, 64'h0000_0000_0000_0001);
    send_item(KIND_LAST, 64'h3FE0_0000_0000_0000);
    send_item(KIND_ELEM, 64'h7FF0_0000_0000_0000);
    send_item(KIND_LAST, BITS_ZERO);
    send_item(KIND_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_min_max_cases();
    set_mode(OP_MIN);
    send_item(KIND_ELEM, BITS_ZERO);
    send_item(KIND_ELEM, 64'h8000_0000_0000_0000);
    send_item(KIND_ELEM, 64'h7FF8_0000_0000_0001);
    send_item(KIND_LAST, 64'hBFF0_0000_0000_0000);
    set_mode(OP_MAX);
    send_item(KIND_ELEM, 64'h7FF4_0000_0000_0000);
    send_item(KIND_ELEM, 64'h7FF0_0000_0000_0000);
    send_item(KIND_LAST, 64'hFFF0_0000_0000_0000);
  endtask

  task automatic test_mode_switch_mid_vector();
    set_mode(OP_SUM);
    send_item(KIND_ELEM, 64'h4000_0000_0000_0000);
    set_mode(OP_PRODUCT);
    send_item(KIND_ELEM, 64'h4008_0000_0000_0000);
    set_mode(OP_MAX);
    send_item(KIND_LAST, 64'h4010_0000_0000_0000);
  endtask

  task automatic test_backpressure();
    set_mode(OP_SUM);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(rand_kind(), rand_element());
    wait_drained();
  endtask

  task automatic test_random_stream();
    op_t m;
    burst_left = 0;
    for (int blk = 0; blk < 7; blk++) begin
      m = (blk < 4) ? op_t'(blk) : op_t'($urandom_range(0, 3));
      set_mode(m);
      for (int i = 0; i < 150; i++) send_bursty(rand_kind(), rand_element());
    end
  endtask

  // ---------------- receiver, checker, watchdog ----------------
  initial begin
    int seg_left;
    int style;
    seg_left = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        style = $urandom_range(0, 2);
      end
      seg_left--;
      case (style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic report(input string what, input logic [DW-1:0] got, input logic [DW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reduction_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected transfer", out_result_value, '0);
      end else begin
        w = pending_results.pop_front();
        if (out_result_value !== w.value) report("result_value", out_result_value, w.value);
        if (out_status !== w.status) report("status", 64'(out_status), 64'(w.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    in_valid = 1'b0;
    in_kind = KIND_ELEM;
    in_element_value = '0;
    out_ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    burst_left = 0;
    cur_op = OP_SUM;
    running_acc = BITS_ZERO;
    no_elem_yet = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_empty_vectors();
    test_sum_cases();
    test_product_cases();
    test_min_max_cases();
    test_mode_switch_mid_vector();
    test_backpressure();
    test_random_stream();

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
